FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/aet_pkg.sv
`default_nettype none

package aet_pkg;

   // token kinds
   localparam logic [3:0] KIND_INT        = 4'd0;
   localparam logic [3:0] KIND_PLUS       = 4'd1;
   localparam logic [3:0] KIND_MINUS      = 4'd2;
   localparam logic [3:0] KIND_STAR       = 4'd3;
   localparam logic [3:0] KIND_SLASH      = 4'd4;
   localparam logic [3:0] KIND_OPEN       = 4'd5;
   localparam logic [3:0] KIND_CLOSE      = 4'd6;
   localparam logic [3:0] KIND_UNKNOWN    = 4'd7;
   localparam logic [3:0] KIND_UNTERM     = 4'd8;

   // characters
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_OPEN       = 8'h28;
   localparam logic [7:0] CHAR_CLOSE      = 8'h29;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_VTAB       = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED   = 8'h0C;
   localparam logic [7:0] CHAR_RETURN     = 8'h0D;

   // token queue between scanner and output stage
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_DEPTH    = 4;

   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_INT    = 6'b000010,
      MODE_SLASH  = 6'b000100,
      MODE_LINE   = 6'b001000,
      MODE_BLOCK  = 6'b010000,
      MODE_BSTAR  = 6'b100000
   } aet_mode_type;

   // which of the two token slots of a queue entry hold a token
   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } aet_flags_type;

endpackage

`default_nettype wire

FILE: hw/rtl/aet_front.sv
`default_nettype none

module aet_front #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int TOK_W         = 4 + 3 * POSITION_BITS + LENGTH_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_char_code,
   input  wire logic                  req_end_of_source,
   output logic                       push_valid,
   output aet_pkg::aet_flags_type     push_flags,
   output logic [2*TOK_W-1:0]         push_data,
   input  wire logic                  push_full
);

   localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

   aet_pkg::aet_mode_type      mode_ff, mode_in;
   logic [POSITION_BITS-1:0]   off_ff, off_in, line_ff, line_in, col_ff, col_in;
   logic [POSITION_BITS-1:0]   st_off_ff, st_off_in, st_line_ff, st_line_in;
   logic [POSITION_BITS-1:0]   st_col_ff, st_col_in;
   logic [LENGTH_BITS-1:0]     len_ff, len_in, len_inc;

   logic                       accept, fresh, is_digit, is_space;
   logic [7:0]                 c;
   logic                       a_valid, b_valid;
   logic [3:0]                 a_kind, b_kind;
   logic [LENGTH_BITS-1:0]     a_len, b_len;
   logic [POSITION_BITS-1:0]   b_off, b_line, b_col;

   assign req_stall = push_full;
   assign accept    = req_valid && !push_full;
   assign c         = req_char_code;

   assign is_digit = (c >= aet_pkg::CHAR_ZERO) && (c <= aet_pkg::CHAR_NINE);
   assign is_space = (c == aet_pkg::CHAR_SPACE) || (c == aet_pkg::CHAR_TAB) ||
                     (c == aet_pkg::CHAR_NEWLINE) || (c == aet_pkg::CHAR_VTAB) ||
                     (c == aet_pkg::CHAR_FORMFEED) || (c == aet_pkg::CHAR_RETURN);
   assign len_inc  = (len_ff == {LENGTH_BITS{1'b1}}) ? len_ff : len_ff + 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      len_in     = len_ff;
      st_off_in  = st_off_ff;
      st_line_in = st_line_ff;
      st_col_in  = st_col_ff;
      fresh      = 1'b0;
      a_valid    = 1'b0;
      a_kind     = aet_pkg::KIND_INT;
      a_len      = len_ff;
      b_valid    = 1'b0;
      b_kind     = aet_pkg::KIND_INT;
      b_len      = LEN_ONE;
      b_off      = st_off_ff;
      b_line     = st_line_ff;
      b_col      = st_col_ff;

      unique case (mode_ff)
         aet_pkg::MODE_INT: begin
            if (is_digit) begin
               len_in = len_inc;
            end else begin
               a_valid = 1'b1;
               fresh   = 1'b1;
            end
         end
         aet_pkg::MODE_SLASH: begin
            if (c == aet_pkg::CHAR_SLASH) begin
               mode_in = aet_pkg::MODE_LINE;
            end else if (c == aet_pkg::CHAR_STAR) begin
               mode_in = aet_pkg::MODE_BLOCK;
               len_in  = len_inc;
            end else begin
               a_valid = 1'b1;
               a_kind  = aet_pkg::KIND_SLASH;
               a_len   = LEN_ONE;
               fresh   = 1'b1;
            end
         end
         aet_pkg::MODE_LINE: begin
            if (c == aet_pkg::CHAR_NEWLINE) mode_in = aet_pkg::MODE_NORMAL;
         end
         aet_pkg::MODE_BLOCK: begin
            len_in = len_inc;
            if (c == aet_pkg::CHAR_STAR) mode_in = aet_pkg::MODE_BSTAR;
         end
         aet_pkg::MODE_BSTAR: begin
            len_in = len_inc;
            if (c == aet_pkg::CHAR_SLASH) begin
               mode_in = aet_pkg::MODE_NORMAL;
            end else if (c != aet_pkg::CHAR_STAR) begin
               mode_in = aet_pkg::MODE_BLOCK;
            end
         end
         default: fresh = 1'b1;
      endcase

      // start a new token at this byte
      if (fresh) begin
         mode_in    = aet_pkg::MODE_NORMAL;
         st_off_in  = off_ff;
         st_line_in = line_ff;
         st_col_in  = col_ff;
         len_in     = LEN_ONE;
         b_off      = off_ff;
         b_line     = line_ff;
         b_col      = col_ff;
         priority if (is_digit) begin
            mode_in = aet_pkg::MODE_INT;
         end else if (c == aet_pkg::CHAR_SLASH) begin
            mode_in = aet_pkg::MODE_SLASH;
         end else if (c == aet_pkg::CHAR_PLUS) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_PLUS;
         end else if (c == aet_pkg::CHAR_MINUS) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_MINUS;
         end else if (c == aet_pkg::CHAR_STAR) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_STAR;
         end else if (c == aet_pkg::CHAR_OPEN) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_OPEN;
         end else if (c == aet_pkg::CHAR_CLOSE) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_CLOSE;
         end else begin
            b_valid = !is_space;
            b_kind  = aet_pkg::KIND_UNKNOWN;
         end
      end

      off_in = (off_ff == {POSITION_BITS{1'b1}}) ? off_ff : off_ff + 1'b1;
      if (c == aet_pkg::CHAR_NEWLINE) begin
         line_in = (line_ff == {POSITION_BITS{1'b1}}) ? line_ff : line_ff + 1'b1;
         col_in  = '0;
      end else begin
         line_in = line_ff;
         col_in  = (col_ff == {POSITION_BITS{1'b1}}) ? col_ff : col_ff + 1'b1;
      end

      // flush whatever is still open, then start over
      if (req_end_of_source) begin
         if (mode_in == aet_pkg::MODE_INT) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_INT;
            b_len   = len_in;
         end else if (mode_in == aet_pkg::MODE_SLASH) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_SLASH;
            b_len   = LEN_ONE;
         end else if (mode_in == aet_pkg::MODE_BLOCK || mode_in == aet_pkg::MODE_BSTAR) begin
            b_valid = 1'b1;
            b_kind  = aet_pkg::KIND_UNTERM;
            b_len   = len_in;
         end
         mode_in    = aet_pkg::MODE_NORMAL;
         off_in     = '0;
         line_in    = '0;
         col_in     = '0;
         st_off_in  = '0;
         st_line_in = '0;
         st_col_in  = '0;
         len_in     = '0;
      end
   end

   assign push_valid              = accept && (a_valid || b_valid);
   assign push_flags.first_valid  = a_valid;
   assign push_flags.second_valid = b_valid;
   assign push_data = {a_kind, st_off_ff, st_line_ff, st_col_ff, a_len,
                       b_kind, b_off, b_line, b_col, b_len};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= aet_pkg::MODE_NORMAL;
         off_ff     <= '0;
         line_ff    <= '0;
         col_ff     <= '0;
         st_off_ff  <= '0;
         st_line_ff <= '0;
         st_col_ff  <= '0;
         len_ff     <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         off_ff     <= off_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         st_off_ff  <= st_off_in;
         st_line_ff <= st_line_in;
         st_col_ff  <= st_col_in;
         len_ff     <= len_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/aet_fifo.sv
`default_nettype none

module aet_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   input  wire aet_pkg::aet_flags_type  push_flags,
   input  wire logic [WIDTH-1:0]        push_data,
   output logic                         full,
   output logic                         head_valid,
   output aet_pkg::aet_flags_type       head_flags,
   output logic [WIDTH-1:0]             head_data,
   input  wire logic                    pop
);

   localparam int PTR = aet_pkg::QUEUE_PTR_BITS;

   aet_pkg::aet_flags_type  flags_ff [aet_pkg::QUEUE_DEPTH];
   logic [WIDTH-1:0]        data_ff  [aet_pkg::QUEUE_DEPTH];
   logic [PTR-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [PTR:0]            count_ff, count_in;

   assign full       = (count_ff == (PTR+1)'(aet_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_flags = flags_ff[rd_ptr_ff];
   assign head_data  = data_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)        rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         data_ff[wr_ptr_ff]  <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/aet_back.sv
`default_nettype none

module aet_back #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int TOK_W         = 4 + 3 * POSITION_BITS + LENGTH_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire aet_pkg::aet_flags_type    head_flags,
   input  wire logic [2*TOK_W-1:0]        head_data,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [3:0]                     rsp_token_kind,
   output logic [POSITION_BITS-1:0]       rsp_start_offset,
   output logic [POSITION_BITS-1:0]       rsp_start_line,
   output logic [POSITION_BITS-1:0]       rsp_token_column,
   output logic [LENGTH_BITS-1:0]         rsp_token_length,
   output logic                           rsp_last_of_run
);

   logic               rsp_valid_ff, second_ff, last_ff;
   logic [TOK_W-1:0]   tok_ff;
   logic               load, take_b;

   assign load   = !rsp_valid_ff || !rsp_stall;
   // the first slot goes out first; the second slot or a lone token pops the entry
   assign take_b = second_ff || !head_flags.first_valid;
   assign pop    = load && head_valid && (take_b || !head_flags.second_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) second_ff <= !take_b && head_flags.second_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         tok_ff  <= take_b ? head_data[TOK_W-1:0] : head_data[2*TOK_W-1:TOK_W];
         last_ff <= take_b || !head_flags.second_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_token_kind   = tok_ff[TOK_W-1 -: 4];
   assign rsp_start_offset = tok_ff[LENGTH_BITS + 3*POSITION_BITS - 1 -: POSITION_BITS];
   assign rsp_start_line   = tok_ff[LENGTH_BITS + 2*POSITION_BITS - 1 -: POSITION_BITS];
   assign rsp_token_column = tok_ff[LENGTH_BITS + POSITION_BITS - 1 -: POSITION_BITS];
   assign rsp_token_length = tok_ff[LENGTH_BITS-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/arithmetic_expression_tokenizer.sv
// A token enters the token queue when the byte that completes it is taken, then
//   passes to the output register; the second token of the same byte follows it.
// Throughput: one byte per cycle if the queue has room; the output stage sends one
//   token per cycle unless stalled; a four-entry queue absorbs two-token bytes.
// Reset (synchronous, active high): scanner back to normal mode at offset, line and
//   column zero, token queue and output register emptied.
`default_nettype none

module arithmetic_expression_tokenizer #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_char_code,
   input  wire logic                      req_end_of_source,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [3:0]                     rsp_token_kind,
   output logic [POSITION_BITS-1:0]       rsp_start_offset,
   output logic [POSITION_BITS-1:0]       rsp_start_line,
   output logic [POSITION_BITS-1:0]       rsp_token_column,
   output logic [LENGTH_BITS-1:0]         rsp_token_length,
   output logic                           rsp_last_of_run
);

   localparam int TOK_W = 4 + 3 * POSITION_BITS + LENGTH_BITS;

   logic                     push_valid, push_full, head_valid, pop;
   aet_pkg::aet_flags_type   push_flags, head_flags;
   logic [2*TOK_W-1:0]       push_data, head_data;

   aet_front #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS),
      .TOK_W         (TOK_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_source (req_end_of_source),
      .push_valid        (push_valid),
      .push_flags        (push_flags),
      .push_data         (push_data),
      .push_full         (push_full)
   );

   aet_fifo #(
      .WIDTH (2 * TOK_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_flags (push_flags),
      .push_data  (push_data),
      .full       (push_full),
      .head_valid (head_valid),
      .head_flags (head_flags),
      .head_data  (head_data),
      .pop        (pop)
   );

   aet_back #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS),
      .TOK_W         (TOK_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_flags       (head_flags),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_start_line   (rsp_start_line),
      .rsp_token_column (rsp_token_column),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/aet_checker.sv
`default_nettype none
`include "assert_macros.svh"

module aet_checker #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic [7:0]                req_char_code,
   input  wire logic                      req_end_of_source,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic [3:0]                rsp_token_kind,
   input  wire logic [POSITION_BITS-1:0]  rsp_start_offset,
   input  wire logic [POSITION_BITS-1:0]  rsp_start_line,
   input  wire logic [POSITION_BITS-1:0]  rsp_token_column,
   input  wire logic [LENGTH_BITS-1:0]    rsp_token_length,
   input  wire logic                      rsp_last_of_run
);

   logic single_char;

   assign single_char = (rsp_token_kind == aet_pkg::KIND_PLUS) ||
                        (rsp_token_kind == aet_pkg::KIND_MINUS) ||
                        (rsp_token_kind == aet_pkg::KIND_STAR) ||
                        (rsp_token_kind == aet_pkg::KIND_SLASH) ||
                        (rsp_token_kind == aet_pkg::KIND_OPEN) ||
                        (rsp_token_kind == aet_pkg::KIND_CLOSE) ||
                        (rsp_token_kind == aet_pkg::KIND_UNKNOWN);

   `ASSERT_CLK(a_reset_empties_output, clock, reset |=> !rsp_valid, "response after reset")

   `ASSERT_CLK_RST(a_stalled_req_holds, clock, reset,
      req_valid && req_stall |=> req_valid && $stable(req_char_code) &&
      $stable(req_end_of_source), "stalled request changed")

   `ASSERT_CLK_RST(a_stalled_rsp_holds, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_start_offset) && $stable(rsp_start_line) &&
      $stable(rsp_token_column) && $stable(rsp_token_length) &&
      $stable(rsp_last_of_run), "stalled response changed")

   `ASSERT_CLK_RST(a_single_char_length, clock, reset,
      rsp_valid && single_char |-> rsp_token_length == LENGTH_BITS'(1),
      "operator or unknown token length is not one")

   `ASSERT_CLK_RST(a_unterm_is_last, clock, reset,
      rsp_valid && rsp_token_kind == aet_pkg::KIND_UNTERM |-> rsp_last_of_run,
      "unterminated comment token not last of its byte")

endmodule

bind arithmetic_expression_tokenizer aet_checker #(
   .POSITION_BITS (POSITION_BITS),
   .LENGTH_BITS   (LENGTH_BITS)
) u_aet_checker (.*);

`default_nettype wire
